// ===== src/lfu_pkg.sv =====
// shared constants and types for the lfu page replacement block
`default_nettype none
package lfu_pkg;

	// field widths fixed by the interface
	localparam int PAGE_W = 10;
	localparam int CFG_W  = 5;

	// frames_in_use after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// defaults for the top level parameters
	localparam int              FRAMES_DEF    = 16;
	localparam longint unsigned COUNT_MAX_DEF = 64'd65535;

	// item queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// queue status seen by the back end
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// ===== src/lfu_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/lfu_front.sv =====
// front end: accepts page references into a short queue
`default_nettype none
module lfu_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lfu_pkg::PAGE_W-1:0] page_number,
	output logic                            busy,
	input  wire logic                       pop,
	output logic      [lfu_pkg::PAGE_W-1:0] head,
	output lfu_pkg::q_status_t              status
);

	logic [lfu_pkg::PAGE_W-1:0] ent_q [lfu_pkg::QDEPTH];
	logic [lfu_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lfu_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lfu_pkg::QCNT_W-1:0] cnt_q;
	logic                       push;

	// queue flags
	always_comb begin
		status.full  = (cnt_q == lfu_pkg::QCNT_W'(lfu_pkg::QDEPTH));
		status.empty = (cnt_q == '0);
	end

	assign busy = status.full;
	assign push = start && !status.full;
	assign head = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// item storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= page_number;
		end
	end

endmodule
`default_nettype wire

// ===== src/lfu_engine.sv =====
// back end: frame scan, victim choice and table update
`default_nettype none
module lfu_engine #(
	parameter int              FRAMES    = lfu_pkg::FRAMES_DEF,
	parameter longint unsigned COUNT_MAX = lfu_pkg::COUNT_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic [lfu_pkg::CFG_W-1:0]  cfg_data,
	input  wire lfu_pkg::q_status_t         q_status,
	input  wire logic [lfu_pkg::PAGE_W-1:0] q_head,
	output logic                            pop,
	output logic                            done,
	output logic                            hit,
	output logic                            evicted_valid,
	output logic      [lfu_pkg::PAGE_W-1:0] evicted_page
);

	localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int OCC_W   = $clog2(FRAMES + 1);
	localparam int CNT_W   = $clog2(COUNT_MAX + 64'd1);
	localparam int ENT_W   = lfu_pkg::PAGE_W + CNT_W;
	localparam int LIM_W   = 8;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                  state_q;
	logic [FRAME_W:0]            cnt_q;
	logic                        chk_vld_s1;
	logic [FRAME_W-1:0]          chk_idx_s1;
	logic [lfu_pkg::CFG_W-1:0]   limit_cfg_q;
	logic [lfu_pkg::PAGE_W-1:0]  page_q;
	logic                        hit_fnd_q;
	logic [FRAME_W-1:0]          hit_idx_q;
	logic [CNT_W-1:0]            hit_cnt_q;
	logic                        vic_fnd_q;
	logic [FRAME_W-1:0]          vic_idx_q;
	logic [CNT_W-1:0]            vic_cnt_q;
	logic [FRAME_W-1:0]          vic_rank_q;
	logic [lfu_pkg::PAGE_W-1:0]  vic_page_q;
	logic                        free_fnd_q;
	logic [FRAME_W-1:0]          free_idx_q;
	logic                        valid_q [FRAMES];
	logic [FRAME_W-1:0]          rank_q [FRAMES];
	logic [OCC_W-1:0]            occ_q;

	logic                        ram_we;
	logic [FRAME_W-1:0]          ram_waddr;
	logic [ENT_W-1:0]            ram_wdata;
	logic                        ram_re;
	logic [FRAME_W-1:0]          ram_raddr;
	logic [ENT_W-1:0]            ram_rdata;

	logic [lfu_pkg::PAGE_W-1:0]  rd_page;
	logic [CNT_W-1:0]            rd_cnt;
	logic                        rd_valid;
	logic [FRAME_W-1:0]          rd_rank;
	logic                        take_vic;
	logic [LIM_W-1:0]            limit;
	logic                        evict;
	logic [FRAME_W-1:0]          slot;
	logic [FRAME_W-1:0]          hit_rank;
	logic [CNT_W-1:0]            hit_cnt_nxt;

	// page tag and use count per frame
	lfu_ram #(
		.WIDTH (ENT_W),
		.DEPTH (FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// scan read side
	assign pop       = (state_q == ST_IDLE) && !q_status.empty;
	assign ram_re    = (state_q == ST_SCAN) && (cnt_q < (FRAME_W + 1)'(FRAMES));
	assign ram_raddr = cnt_q[FRAME_W-1:0];
	assign rd_page   = ram_rdata[ENT_W-1 -: lfu_pkg::PAGE_W];
	assign rd_cnt    = ram_rdata[CNT_W-1:0];
	assign rd_valid  = valid_q[chk_idx_s1];
	assign rd_rank   = rank_q[chk_idx_s1];

	// lowest count wins, older rank breaks a tie
	assign take_vic = rd_valid && (!vic_fnd_q || (rd_cnt < vic_cnt_q) ||
		((rd_cnt == vic_cnt_q) && (rd_rank > vic_rank_q)));

	// clamped frame limit and update decisions
	always_comb begin
		if (limit_cfg_q == '0) begin
			limit = LIM_W'(1);
		end else if (LIM_W'(limit_cfg_q) > LIM_W'(FRAMES)) begin
			limit = LIM_W'(FRAMES);
		end else begin
			limit = LIM_W'(limit_cfg_q);
		end
		evict       = (LIM_W'(occ_q) >= limit) && vic_fnd_q;
		slot        = hit_fnd_q ? hit_idx_q : (evict ? vic_idx_q : free_idx_q);
		hit_rank    = rank_q[hit_idx_q];
		hit_cnt_nxt = (hit_cnt_q == CNT_W'(COUNT_MAX)) ? hit_cnt_q : hit_cnt_q + 1'b1;
	end

	// table write at the end of an item
	always_comb begin
		ram_we    = (state_q == ST_UPD) && (hit_fnd_q || evict || free_fnd_q);
		ram_waddr = slot;
		ram_wdata = hit_fnd_q ? {page_q, hit_cnt_nxt} : {page_q, CNT_W'(1)};
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			chk_vld_s1  <= 1'b0;
			limit_cfg_q <= lfu_pkg::CFG_RESET;
			hit_fnd_q   <= 1'b0;
			vic_fnd_q   <= 1'b0;
			free_fnd_q  <= 1'b0;
			occ_q       <= '0;
			done        <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			done       <= 1'b0;
			chk_vld_s1 <= ram_re;
			if (cfg_valid) begin
				limit_cfg_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cnt_q      <= '0;
						hit_fnd_q  <= 1'b0;
						vic_fnd_q  <= 1'b0;
						free_fnd_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (chk_vld_s1) begin
						if (rd_valid && (rd_page == page_q)) begin
							hit_fnd_q <= 1'b1;
						end
						if (take_vic) begin
							vic_fnd_q <= 1'b1;
						end
						if (!rd_valid) begin
							free_fnd_q <= 1'b1;
						end
						if (chk_idx_s1 == FRAME_W'(FRAMES - 1)) begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
					if (!hit_fnd_q) begin
						if (evict || free_fnd_q) begin
							valid_q[slot] <= 1'b1;
						end
						if (!evict && free_fnd_q) begin
							occ_q <= occ_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan payload, recency ranks and result fields
	always_ff @(posedge clk) begin
		if (ram_re) begin
			chk_idx_s1 <= ram_raddr;
		end
		if (state_q == ST_IDLE && pop) begin
			page_q <= q_head;
		end
		if (state_q == ST_SCAN && chk_vld_s1) begin
			if (rd_valid && (rd_page == page_q)) begin
				hit_idx_q <= chk_idx_s1;
				hit_cnt_q <= rd_cnt;
			end
			if (take_vic) begin
				vic_idx_q  <= chk_idx_s1;
				vic_cnt_q  <= rd_cnt;
				vic_rank_q <= rd_rank;
				vic_page_q <= rd_page;
			end
			if (!rd_valid && !free_fnd_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
		if (state_q == ST_UPD) begin
			hit           <= hit_fnd_q;
			evicted_valid <= !hit_fnd_q && evict;
			evicted_page  <= (!hit_fnd_q && evict) ? vic_page_q : '0;
			for (int i = 0; i < FRAMES; i++) begin
				if (valid_q[i] && (FRAME_W'(i) != slot)) begin
					if (hit_fnd_q) begin
						if (rank_q[i] < hit_rank) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end else if (evict) begin
						if (rank_q[i] <= vic_rank_q) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end else if (free_fnd_q) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
			if (hit_fnd_q || evict || free_fnd_q) begin
				rank_q[slot] <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/lfu_page_replacement_top.sv =====
// top level of the lfu page replacement block
// an item taken by start waits in the queue, is scanned against every frame, then the
// table is updated and done is raised; items are handled one at a time, the scan reading
//   one frame entry per cycle from the tag and count ram
// two items may wait in the front queue; busy is high while it is full
// reset clears frame valid bits, occupancy, queue and limit (to 16) at once
`default_nettype none
module lfu_page_replacement_top #(
	parameter int              FRAMES    = lfu_pkg::FRAMES_DEF,
	parameter longint unsigned COUNT_MAX = lfu_pkg::COUNT_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [lfu_pkg::PAGE_W-1:0] page_number,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lfu_pkg::CFG_W-1:0]  frames_in_use,
	output logic                            done,
	output logic                            hit,
	output logic                            evicted_valid,
	output logic      [lfu_pkg::PAGE_W-1:0] evicted_page
);

	lfu_pkg::q_status_t         q_status;
	logic [lfu_pkg::PAGE_W-1:0] q_head;
	logic                       pop;
	logic                       cfg_wr;

	// limit register is always writable
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// item intake
	lfu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.page_number (page_number),
		.busy        (busy),
		.pop         (pop),
		.head        (q_head),
		.status      (q_status)
	);

	// lookup and replacement
	lfu_engine #(
		.FRAMES    (FRAMES),
		.COUNT_MAX (COUNT_MAX)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_wr),
		.cfg_data      (frames_in_use),
		.q_status      (q_status),
		.q_head        (q_head),
		.pop           (pop),
		.done          (done),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page)
	);

	// checks
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("item taken from an empty queue");

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !evicted_valid)
		else $error("eviction reported on a hit");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted_valid) |-> (evicted_page == '0))
		else $error("evicted page not zero without eviction");

	a_pop_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && $past(q_status.empty)) |-> $past(start && !busy))
		else $error("queue went non-empty without an accepted item");

endmodule
`default_nettype wire

// ===== test/lfu_page_replacement_top_test.sv =====
// self-checking testbench for the lfu page replacement block with lru tie break
module lfu_page_replacement_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lfu_pkg::*;

	localparam int              FRAMES    = FRAMES_DEF;
	localparam longint unsigned COUNT_MAX = COUNT_MAX_DEF;

	// one expected outcome per accepted item
	typedef struct packed {
		logic              hit;
		logic              ev_valid;
		logic [PAGE_W-1:0] ev_page;
	} outcome_t;

	// frame table predictor and queue of outcomes still to arrive
	class lfu_residency_model;
		bit                valid [FRAMES];
		logic [PAGE_W-1:0] page [FRAMES];
		int unsigned       count [FRAMES];
		int unsigned       rank [FRAMES];
		int unsigned       occupancy;
		logic [CFG_W-1:0]  limit_reg;
		outcome_t          outcome_q[$];
		int                errors;

		function new();
			for (int i = 0; i < FRAMES; i++) begin
				valid[i] = 1'b0;
				page[i]  = '0;
				count[i] = 0;
				rank[i]  = 0;
			end
			occupancy = 0;
			limit_reg = CFG_RESET;
			errors    = 0;
		endfunction

		function void set_limit(logic [CFG_W-1:0] v);
			limit_reg = v;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// work out the outcome of one accepted item and update the frame table
		function void note_page(logic [PAGE_W-1:0] p);
			int          slot;
			int          victim;
			int unsigned old_rank;
			int unsigned lim;
			outcome_t    o;
			slot = -1;
			o    = '0;
			for (int i = 0; i < FRAMES; i++)
				if (slot < 0 && valid[i] && page[i] == p)
					slot = i;
			if (slot >= 0) begin
				// hit: saturating count, page becomes most recent
				if (count[slot] < COUNT_MAX)
					count[slot]++;
				old_rank = rank[slot];
				for (int i = 0; i < FRAMES; i++)
					if (valid[i] && i != slot && rank[i] < old_rank)
						rank[i]++;
				rank[slot] = 0;
				o.hit = 1'b1;
			end else begin
				// zero acts as one, anything above the table size as the table size
				lim = limit_reg;
				if (lim < 1)
					lim = 1;
				if (lim > FRAMES)
					lim = FRAMES;
				if (occupancy >= lim) begin
					// lowest count wins, oldest among equal counts
					victim = -1;
					for (int i = 0; i < FRAMES; i++)
						if (valid[i] && (victim < 0 || count[i] < count[victim] ||
								(count[i] == count[victim] && rank[i] > rank[victim])))
							victim = i;
					if (victim >= 0) begin
						o.ev_valid = 1'b1;
						o.ev_page  = page[victim];
						for (int i = 0; i < FRAMES; i++)
							if (valid[i] && i != victim && rank[i] > rank[victim])
								rank[i]--;
						valid[victim] = 1'b0;
						occupancy--;
						slot = victim;
					end
				end
				if (slot < 0)
					for (int i = 0; i < FRAMES; i++)
						if (slot < 0 && !valid[i])
							slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < FRAMES; i++)
						if (valid[i])
							rank[i]++;
					valid[slot] = 1'b1;
					page[slot]  = p;
					count[slot] = 1;
					rank[slot]  = 0;
					occupancy++;
				end
			end
			outcome_q.push_back(o);
		endfunction

		// compare one result with the oldest outcome still waiting
		function void check_result(logic h, logic ev, logic [PAGE_W-1:0] ep);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				$error("result with no item waiting: hit %0d evicted %0d page %0d",
					h, ev, ep);
				errors++;
				return;
			end
			o = outcome_q.pop_front();
			if (h !== o.hit) begin
				$error("hit: expected %0d, got %0d", o.hit, h);
				errors++;
			end
			if (ev !== o.ev_valid) begin
				$error("evicted_valid: expected %0d, got %0d", o.ev_valid, ev);
				errors++;
			end
			if (ep !== o.ev_page) begin
				$error("evicted_page: expected %0d, got %0d", o.ev_page, ep);
				errors++;
			end
		endfunction
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              start         = 1'b0;
	logic [PAGE_W-1:0] page_number   = '0;
	logic              cfg_valid     = 1'b0;
	logic [CFG_W-1:0]  frames_in_use = '0;
	logic              busy;
	logic              cfg_ready;
	logic              done;
	logic              hit;
	logic              evicted_valid;
	logic [PAGE_W-1:0] evicted_page;

	lfu_residency_model frames_model;

	lfu_page_replacement_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_number   (page_number),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.frames_in_use (frames_in_use),
		.done          (done),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// results are strobed for one cycle and cannot be held off
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			frames_model.check_result(hit, evicted_valid, evicted_page);
	end

	// present one item after a gap and hold it until it is taken
	task automatic send_page(logic [PAGE_W-1:0] p, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		page_number <= p;
		do @(posedge clk); while (busy);
		frames_model.note_page(p);
	endtask

	// drain all outstanding results before touching the limit
	task automatic wait_idle();
		start <= 1'b0;
		while (frames_model.pending() != 0) @(posedge clk);
		repeat (FRAMES + 8) @(posedge clk);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] v);
		cfg_valid     <= 1'b1;
		frames_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		frames_model.set_limit(v);
		cfg_valid <= 1'b0;
	endtask

	// random items: mostly a skewed hot set so hits and evictions both occur
	task automatic run_mix(int n, int pool_size);
		logic [PAGE_W-1:0] pool [32];
		logic [PAGE_W-1:0] last;
		logic [PAGE_W-1:0] p;
		int                r;
		int                gap;
		bit                quiet;
		for (int i = 0; i < pool_size; i++)
			pool[i] = PAGE_W'($urandom_range(0, 1023));
		last  = pool[0];
		quiet = 1'b0;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 70)
				p = pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
			else if (r < 85)
				p = PAGE_W'($urandom_range(0, 1023));
			else
				p = last;
			gap = quiet ? 0 : $urandom_range(0, 12);
			send_page(p, gap);
			last = p;
		end
	endtask

	// stimulus
	initial begin
		int limits [8];
		int lim;
		frames_model = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limit zero behaves as one frame
		write_limit(5'd0);
		send_page(10'd7, 0);
		send_page(10'd7, 1);
		send_page(10'd8, 0);
		send_page(10'd9, 3);
		send_page(10'd1023, 0);
		send_page(10'd0, 0);

		// limit one
		wait_idle();
		write_limit(5'd1);
		send_page(10'd0, 0);
		send_page(10'd0, 2);
		send_page(10'd5, 0);

		// three frames: counts decide the victim, recency breaks ties
		wait_idle();
		write_limit(5'd3);
		send_page(10'd1023, 0);
		send_page(10'd512, 0);
		send_page(10'd0, 5);
		send_page(10'd1023, 0);
		send_page(10'd1023, 0);
		send_page(10'd511, 0);

		// limit lowered below occupancy: filled frames stay resident
		wait_idle();
		write_limit(5'd2);
		send_page(10'd100, 0);
		send_page(10'd200, 12);
		send_page(10'd511, 0);

		// random phases over a range of limits, above the table size too
		limits = '{5, 9, 4, 12, 16, 31, 17, 16};
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_limit(CFG_W'(limits[ph]));
			lim = (limits[ph] > FRAMES) ? FRAMES : limits[ph];
			run_mix(235, lim + $urandom_range(1, 8));
		end

		// hammer one page so its count grows, then flood with misses
		wait_idle();
		for (int k = 0; k < 20; k++)
			send_page(10'd321, 0);
		for (int k = 0; k < 20; k++)
			send_page(PAGE_W'(900 + k), 0);
		send_page(10'd321, 0);

		// drain and report
		start <= 1'b0;
		while (frames_model.pending() != 0) @(posedge clk);
		repeat (FRAMES + 8) @(posedge clk);
		if (frames_model.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule
